// File: rtl/ecgard_pkg.sv
// Package for the ECG artifact restart detector.
// Holds field widths, reset values, configuration register codes and the config struct.
// No dependencies.
package ecgard_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int CHANNEL_W = 2;
  localparam int THR_W     = 24;
  localparam int WINDOW_W  = 8;
  localparam int COUNT_W   = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;

  localparam int CHANNELS_DEF       = 3;
  localparam int MEAN_FRAC_BITS_DEF = 10;

  localparam logic [THR_W-1:0]    MEAN_DEV_THR_RST = THR_W'(233333);
  localparam logic [THR_W-1:0]    STEP_THR_RST     = THR_W'(11666);
  localparam logic [THR_W-1:0]    SETTLE_THR_RST   = THR_W'(100);
  localparam logic [WINDOW_W-1:0] SETTLE_WIN_RST   = WINDOW_W'(80);

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MEAN_DEV_THR = 2'd0,
    CFG_STEP_THR     = 2'd1,
    CFG_SETTLE_THR   = 2'd2,
    CFG_SETTLE_WIN   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [THR_W-1:0]    mean_dev_thr;
    logic [THR_W-1:0]    step_thr;
    logic [THR_W-1:0]    settle_thr;
    logic [WINDOW_W-1:0] settle_win;
  } cfg_t;

endpackage

// File: rtl/ecgard_cfg_regs.sv
// Configuration register file of the ECG artifact restart detector.
// Depends on ecgard_pkg for the register codes, widths and reset values.
module ecgard_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ecgard_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ecgard_pkg::CFG_DATA_W-1:0] cfg_data,
  output ecgard_pkg::cfg_t               cfg
);
  import ecgard_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mean_dev_thr <= MEAN_DEV_THR_RST;
      cfg.step_thr     <= STEP_THR_RST;
      cfg.settle_thr   <= SETTLE_THR_RST;
      cfg.settle_win   <= SETTLE_WIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MEAN_DEV_THR: cfg.mean_dev_thr <= THR_W'(cfg_data);
        CFG_STEP_THR:     cfg.step_thr     <= THR_W'(cfg_data);
        CFG_SETTLE_THR:   cfg.settle_thr   <= THR_W'(cfg_data);
        CFG_SETTLE_WIN:   cfg.settle_win   <= cfg_data[WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/ecgard_channel_bank.sv
// Per-channel state (running mean, previous sample, armed flag, settle count)
// and the update that produces the restart decision, computed combinationally from the stored state.
// Depends on ecgard_pkg for widths and the config struct.
module ecgard_channel_bank #(
  parameter int CHANNELS       = ecgard_pkg::CHANNELS_DEF,
  parameter int MEAN_FRAC_BITS = ecgard_pkg::MEAN_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            upd_en,
  input  logic [ecgard_pkg::SAMPLE_W-1:0]  sample,
  input  logic [ecgard_pkg::CHANNEL_W-1:0] channel,
  input  logic                            restart,
  input  ecgard_pkg::cfg_t                cfg,
  output logic                            result
);
  import ecgard_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MW   = SAMPLE_W + MEAN_FRAC_BITS;

  logic [MW-1:0]       mean [CHANNELS];
  logic [SAMPLE_W-1:0] prev [CHANNELS];
  logic                armed [CHANNELS];
  logic [COUNT_W-1:0]  count [CHANNELS];

  logic                chan_ok;
  logic [CH_W-1:0]     idx;
  logic [MW-1:0]       mean_cur, xs, mean_next;
  logic signed [MW:0]  diff, corr, diff2;
  logic [MW:0]         mag;
  logic [SAMPLE_W:0]   dev;
  logic [SAMPLE_W-1:0] step;
  logic                arm_now, armed_eff, settle_clear;
  logic [COUNT_W-1:0]  count_eff, count_next;
  logic                armed_next;

  assign chan_ok = (32'(channel) < 32'(CHANNELS));
  assign idx     = chan_ok ? CH_W'(channel) : '0;

  always_comb begin
    mean_cur = mean[idx];
    xs       = {sample, {MEAN_FRAC_BITS{1'b0}}};
    // Mean moves by the deviation shifted right with floor rounding.
    diff      = $signed({1'b0, xs}) - $signed({1'b0, mean_cur});
    corr      = diff >>> MEAN_FRAC_BITS;
    mean_next = mean_cur + corr[MW-1:0];
    // Deviation against the updated mean, integer part of the magnitude.
    diff2 = diff - corr;
    mag   = diff2[MW] ? (MW+1)'(-diff2) : diff2;
    dev   = mag[MW:MEAN_FRAC_BITS];

    step = (sample >= prev[idx]) ? (sample - prev[idx]) : (prev[idx] - sample);

    arm_now   = (dev > {1'b0, cfg.mean_dev_thr}) && (step > cfg.step_thr);
    armed_eff = armed[idx] || arm_now;
    count_eff = arm_now ? '0 : count[idx];

    settle_clear = armed_eff &&
                   ((count_eff > cfg.settle_win) || (step < cfg.settle_thr));
    armed_next   = armed_eff && !settle_clear;
    result       = 1'b0;
    count_next   = (count_eff == COUNT_MAX) ? count_eff : count_eff + 1'b1;

    if (!chan_ok) begin
      result = 1'b0;
    end else if (restart) begin
      result = 1'b1;
    end else if (settle_clear && (step != '0)) begin
      // A restart raised on settling leaves the count unincremented.
      result     = 1'b1;
      count_next = count_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        mean[c]  <= '0;
        prev[c]  <= '0;
        armed[c] <= 1'b0;
        count[c] <= '0;
      end
    end else if (upd_en && chan_ok) begin
      prev[idx] <= sample;
      if (restart) begin
        mean[idx]  <= xs;
        armed[idx] <= 1'b0;
        count[idx] <= '0;
      end else begin
        mean[idx]  <= mean_next;
        armed[idx] <= armed_next;
        count[idx] <= count_next;
      end
    end
  end

endmodule

// File: rtl/ecg_artifact_restart_detector_top.sv
// ECG artifact restart detector, top level.
// filter_restart follows its input transaction through the input register, then the result register.
// Throughput: one sample per cycle, set by the read-modify-write of the selected channel's state;
// a low out_ready stalls the input once both registers hold a transaction.
// Synchronous reset restores the register defaults and clears all channel state.
module ecg_artifact_restart_detector_top #(
  parameter int CHANNELS       = ecgard_pkg::CHANNELS_DEF,
  parameter int MEAN_FRAC_BITS = ecgard_pkg::MEAN_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ecgard_pkg::SAMPLE_W-1:0]  sample,
  input  logic [ecgard_pkg::CHANNEL_W-1:0] channel,
  input  logic                            restart,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            filter_restart,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ecgard_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ecgard_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ecgard_pkg::*;

  cfg_t                 cfg;
  logic                 s1_valid;
  logic [SAMPLE_W-1:0]  s1_sample;
  logic [CHANNEL_W-1:0] s1_channel;
  logic                 s1_restart;
  logic                 advance;
  logic                 result;

  // The input stage moves on whenever the result register is free or being drained.
  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;

  ecgard_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ecgard_channel_bank #(
    .CHANNELS       (CHANNELS),
    .MEAN_FRAC_BITS (MEAN_FRAC_BITS)
  ) u_bank (
    .clk     (clk),
    .rst     (rst),
    .upd_en  (s1_valid && advance),
    .sample  (s1_sample),
    .channel (s1_channel),
    .restart (s1_restart),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_sample  <= sample;
      s1_channel <= channel;
      s1_restart <= restart;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      filter_restart <= result;
    end
  end

  a_restart_gives_one: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && advance && s1_restart && (32'(s1_channel) < 32'(CHANNELS)))
      |=> (out_valid && filter_restart))
    else $error("restart transaction on a valid channel did not yield a restart");

  a_bad_channel_gives_zero: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && advance && !(32'(s1_channel) < 32'(CHANNELS)))
      |=> (out_valid && !filter_restart))
    else $error("transaction on an unused channel yielded a restart");

  a_free_when_empty: assert property (@(posedge clk) disable iff (rst)
    (!out_valid) |-> in_ready)
    else $error("input stalled while the result register was empty");

endmodule
